@@ rtl/core/acsa_pkg.sv @@
package acsa_pkg;

	localparam int unsigned FS_W = 16;
	localparam int unsigned PER_W = 23;
	localparam int unsigned CFG_W = 23;
	localparam int unsigned SUM_W = 28;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned AVG_W = 16;
	localparam int unsigned RATE_W = 32;
	localparam int unsigned TALLY_W = 16;
	localparam int unsigned CH_W = 3;
	localparam int unsigned NUM_W = 44;
	localparam int unsigned DIV_STEP_W = 6;

	localparam logic [0:0] OP_SAMPLE = 1'b0;
	localparam logic [0:0] OP_PERIOD = 1'b1;

	localparam logic [0:0] REG_FULL_SCALE = 1'b0;
	localparam logic [0:0] REG_PERIOD = 1'b1;

	localparam logic [FS_W-1:0] FULL_SCALE_RESET = 16'd10200;
	localparam logic [PER_W-1:0] PERIOD_RESET = 23'd10000;
	localparam logic [19:0] US_PER_S = 20'd1000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DIV,
		ST_OUT,
		ST_CLEAR
	} acsa_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_start;
		logic div_step;
		logic store;
		logic clear;
		logic [CH_W-1:0] ch;
	} acsa_cmd_t;

	typedef struct packed {
		logic div_done;
	} acsa_sts_t;

endpackage

@@ rtl/core/adc_channel_sample_averager.sv @@
// Averages tagged converter samples per channel. A sample word is taken every cycle
// (stall stays low while idle). A period-end word reports NUM_CHANNELS results, one
// per channel: a load step, a multiply step and a bit-serial divide (44-bit quotient)
// per channel, then an output wait until the result is taken; stall is high
// throughout. Rate and average hold when a channel saw no samples.
module adc_channel_sample_averager #(
	parameter int unsigned NUM_CHANNELS = 7,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [22:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] sample_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  channel,
	output logic [15:0] average_mv,
	output logic [31:0] sample_rate_hz,
	output logic [15:0] samples,
	output logic [15:0] sequence_gaps,
	output logic [15:0] bad_words,
	output logic        last
);

	logic [acsa_pkg::FS_W-1:0] fs_q;
	logic [acsa_pkg::PER_W-1:0] per_q;
	acsa_pkg::acsa_cmd_t cmd;
	acsa_pkg::acsa_sts_t sts;
	logic busy, acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= acsa_pkg::FULL_SCALE_RESET;
			per_q <= acsa_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == acsa_pkg::REG_FULL_SCALE) fs_q <= cfg_data[acsa_pkg::FS_W-1:0];
			else per_q <= cfg_data;
		end
	end

	assign in_stall = busy;
	assign acc = in_valid && !busy;

	acsa_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.period_go(acc && opcode == acsa_pkg::OP_PERIOD),
		.out_taken(!out_stall), .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
	);

	acsa_dp #(.NUM_CHANNELS(NUM_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.word_go(acc && opcode == acsa_pkg::OP_SAMPLE), .word(sample_word),
		.full_scale(fs_q), .period(per_q), .cmd(cmd), .sts(sts),
		.avg_out(average_mv), .rate_out(sample_rate_hz), .cnt_out(samples),
		.gap_out(sequence_gaps), .bad_out(bad_words)
	);

	assign channel = cmd.ch;
	assign last = (cmd.ch == 3'(NUM_CHANNELS - 1));

endmodule

@@ rtl/core/acsa_ctrl.sv @@
module acsa_ctrl #(
	parameter int unsigned NUM_CHANNELS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  period_go,
	input  logic                  out_taken,
	input  acsa_pkg::acsa_sts_t   sts,
	output acsa_pkg::acsa_cmd_t   cmd,
	output logic                  busy,
	output logic                  out_valid
);

	acsa_pkg::acsa_state_t state_q, state_d;
	logic [acsa_pkg::CH_W-1:0] ch_q, ch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acsa_pkg::ST_IDLE;
			ch_q <= '0;
		end else begin
			state_q <= state_d;
			ch_q <= ch_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ch_d = ch_q;
		cmd = '0;
		cmd.ch = ch_q;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			acsa_pkg::ST_IDLE: begin
				busy = 1'b0;
				ch_d = '0;
				if (period_go) state_d = acsa_pkg::ST_LOAD;
			end
			acsa_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = acsa_pkg::ST_MUL;
			end
			acsa_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.div_start = 1'b1;
				state_d = acsa_pkg::ST_DIV;
			end
			acsa_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.store = 1'b1;
					state_d = acsa_pkg::ST_OUT;
				end
			end
			acsa_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_taken) begin
					if (ch_q == acsa_pkg::CH_W'(NUM_CHANNELS - 1)) begin
						state_d = acsa_pkg::ST_CLEAR;
					end else begin
						ch_d = ch_q + 1'b1;
						state_d = acsa_pkg::ST_LOAD;
					end
				end
			end
			acsa_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d = acsa_pkg::ST_IDLE;
			end
			default: state_d = acsa_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/acsa_dp.sv @@
module acsa_dp #(
	parameter int unsigned NUM_CHANNELS = 7,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              word_go,
	input  logic [15:0]                       word,
	input  logic [acsa_pkg::FS_W-1:0]         full_scale,
	input  logic [acsa_pkg::PER_W-1:0]        period,
	input  acsa_pkg::acsa_cmd_t               cmd,
	output acsa_pkg::acsa_sts_t               sts,
	output logic [acsa_pkg::AVG_W-1:0]        avg_out,
	output logic [acsa_pkg::RATE_W-1:0]       rate_out,
	output logic [acsa_pkg::CNT_W-1:0]        cnt_out,
	output logic [acsa_pkg::TALLY_W-1:0]      gap_out,
	output logic [acsa_pkg::TALLY_W-1:0]      bad_out
);

	localparam int unsigned CI_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned DEN_W = acsa_pkg::CNT_W + SAMPLE_BITS;
	localparam int unsigned RNUM_W = acsa_pkg::CNT_W + 20;
	localparam int unsigned STEPS = acsa_pkg::NUM_W;

	logic [acsa_pkg::SUM_W-1:0]   sum_q [NUM_CHANNELS];
	logic [acsa_pkg::CNT_W-1:0]   cnt_q [NUM_CHANNELS];
	logic [acsa_pkg::AVG_W-1:0]   havg_q [NUM_CHANNELS];
	logic [acsa_pkg::RATE_W-1:0]  hrate_q [NUM_CHANNELS];
	logic [acsa_pkg::CH_W-1:0]    prev_q;
	logic [acsa_pkg::TALLY_W-1:0] gap_q, bad_q;

	logic [acsa_pkg::CH_W-1:0] wch, expch;
	logic [SAMPLE_BITS-1:0] code;
	logic [CI_W-1:0] wi, ci;

	assign wch = word[14:12];
	assign code = word[SAMPLE_BITS-1:0];
	assign wi = wch[CI_W-1:0];
	assign ci = cmd.ch[CI_W-1:0];
	assign expch = (prev_q + 1'b1 >= acsa_pkg::CH_W'(NUM_CHANNELS)) ? '0 : prev_q + 1'b1;

	logic [acsa_pkg::SUM_W-1:0]  sum_l;
	logic [acsa_pkg::CNT_W-1:0]  cnt_l;
	logic [acsa_pkg::NUM_W-1:0]  num_a, rem_a;
	logic [DEN_W-1:0]            den_a;
	logic [acsa_pkg::NUM_W-1:0]  quo_a;
	logic [RNUM_W-1:0]           num_r, quo_r;
	logic [acsa_pkg::PER_W:0]    rem_r;
	logic [acsa_pkg::DIV_STEP_W-1:0] step_q;
	logic [DEN_W:0]              tr_a;
	logic [acsa_pkg::PER_W:0]    tr_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
				havg_q[i] <= '0;
				hrate_q[i] <= '0;
			end
			prev_q <= 3'd7;
			gap_q <= '0;
			bad_q <= '0;
		end else begin
			if (word_go && word[15]) begin
				if (wch >= acsa_pkg::CH_W'(NUM_CHANNELS)) begin
					if (bad_q != '1) bad_q <= bad_q + 1'b1;
				end else begin
					if (wch != expch && gap_q != '1) gap_q <= gap_q + 1'b1;
					prev_q <= wch;
					if (cnt_q[wi] != '1) begin
						sum_q[wi] <= sum_q[wi] + acsa_pkg::SUM_W'(code);
						cnt_q[wi] <= cnt_q[wi] + 1'b1;
					end
				end
			end
			if (cmd.store && cnt_l != '0) begin
				havg_q[ci] <= quo_a[acsa_pkg::AVG_W-1:0];
				if (period == '0 || quo_r[RNUM_W-1:acsa_pkg::RATE_W] != '0)
					hrate_q[ci] <= '1;
				else
					hrate_q[ci] <= quo_r[acsa_pkg::RATE_W-1:0];
			end
			if (cmd.clear) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					sum_q[i] <= '0;
					cnt_q[i] <= '0;
				end
				gap_q <= '0;
				bad_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_l <= sum_q[ci];
			cnt_l <= cnt_q[ci];
		end
		if (cmd.mul) begin
			num_a <= acsa_pkg::NUM_W'(sum_l) * acsa_pkg::NUM_W'(full_scale);
			num_r <= RNUM_W'(cnt_l) * RNUM_W'(acsa_pkg::US_PER_S);
			den_a <= {cnt_l, {SAMPLE_BITS{1'b0}}};
			rem_a <= '0;
			rem_r <= '0;
			quo_a <= '0;
			quo_r <= '0;
		end else if (cmd.div_step) begin
			rem_a <= tr_a[DEN_W] ? acsa_pkg::NUM_W'(tr_a[DEN_W-1:0])
				: {rem_a[acsa_pkg::NUM_W-2:0], num_a[acsa_pkg::NUM_W-1]};
			num_a <= {num_a[acsa_pkg::NUM_W-2:0], 1'b0};
			quo_a <= {quo_a[acsa_pkg::NUM_W-2:0], tr_a[DEN_W]};
			if (step_q < acsa_pkg::DIV_STEP_W'(RNUM_W)) begin
				rem_r <= tr_r[acsa_pkg::PER_W] ? {1'b0, tr_r[acsa_pkg::PER_W-1:0]}
					: {rem_r[acsa_pkg::PER_W-1:0], num_r[RNUM_W-1]};
				num_r <= {num_r[RNUM_W-2:0], 1'b0};
				quo_r <= {quo_r[RNUM_W-2:0], tr_r[acsa_pkg::PER_W]};
			end
		end
	end

	// one restoring step each: flag in top bit means subtract fits
	logic [DEN_W+1:0] sh_a;
	logic [acsa_pkg::PER_W+1:0] sh_r;
	always_comb begin
		sh_a = {rem_a[DEN_W:0], num_a[acsa_pkg::NUM_W-1]};
		if (sh_a >= {1'b0, 1'b0, den_a} && den_a != '0)
			tr_a = {1'b1, DEN_W'(sh_a - {2'b00, den_a})};
		else
			tr_a = '0;
		sh_r = {rem_r, num_r[RNUM_W-1]};
		if (sh_r >= {2'b00, period} && period != '0)
			tr_r = {1'b1, acsa_pkg::PER_W'(sh_r - {2'b00, period})};
		else
			tr_r = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= '0;
		else if (cmd.div_start) step_q <= '0;
		else if (cmd.div_step) step_q <= step_q + 1'b1;
	end

	assign sts.div_done = (step_q == acsa_pkg::DIV_STEP_W'(STEPS));

	assign avg_out = havg_q[ci];
	assign rate_out = hrate_q[ci];
	assign cnt_out = cnt_l;
	assign gap_out = gap_q;
	assign bad_out = bad_q;

endmodule
